@@ hw/rtl/mcfe_pkg.sv @@
// Shared types and constants for the motor command frame encoder.
// Holds lane scaling tables, command codes and fixed frame patterns.
// No dependencies.
package mcfe_pkg;

  // Fraction bits of the signed fixed-point set-point inputs
  localparam int FRAC_BITS = 16;

  localparam int IN_W   = 32;   // set-point input width
  localparam int ID_W   = 11;   // CAN identifier width
  localparam int DATA_W = 64;   // frame payload width
  localparam int CMD_W  = 2;

  localparam int NLANE  = 5;    // position, velocity, kp, kd, torque

  // Scaled input: position is multiplied by 100 so 12.57 becomes integral
  localparam int XW = IN_W + 7;
  // Offset from the lower bound, below span * 2^FRAC_BITS (span < 2^12)
  localparam int DW = 12 + FRAC_BITS;
  // Offset times the largest code (codes are at most 16 bits)
  localparam int NW = DW + 16;
  // Quotient dividend after dropping the fraction bits
  localparam int MW = NW - FRAC_BITS;
  // Reciprocal shift: must exceed every dividend
  localparam int RK = MW;
  localparam int PW = 2 * MW;
  // Code width
  localparam int QW = 16;

  // Per lane: input scale, bounds (in scaled units), code width and code LSB in the payload
  localparam int LANE_SCALE [NLANE] = '{100, 1, 1, 1, 1};
  localparam int LANE_LO    [NLANE] = '{-1257, -50, 0, 0, -6};
  localparam int LANE_HI    [NLANE] = '{1257, 50, 500, 5, 6};
  localparam int LANE_BITS  [NLANE] = '{16, 12, 12, 12, 12};
  localparam int LANE_LSB   [NLANE] = '{48, 36, 24, 12, 0};

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CONTROL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENABLE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ZERO    = 2'd3;

  // Fixed frames: seven 0xFF bytes then the command byte
  localparam logic [DATA_W-1:0] FRAME_FILL    = 64'hFFFF_FFFF_FFFF_FF00;
  localparam logic [DATA_W-1:0] FRAME_ENABLE  = FRAME_FILL | 64'h0000_0000_0000_00FC;
  localparam logic [DATA_W-1:0] FRAME_DISABLE = FRAME_FILL | 64'h0000_0000_0000_00FD;
  localparam logic [DATA_W-1:0] FRAME_ZERO    = FRAME_FILL | 64'h0000_0000_0000_00FE;

  localparam logic [ID_W-1:0] MOTOR_ID_RESET = 11'd3;

  // Sideband that travels with each request through the pipeline
  typedef struct packed {
    logic             valid;
    logic [CMD_W-1:0] cmd;
  } mcfe_tag_t;

endpackage

@@ hw/rtl/mit_command_frame_encoder_core.sv @@
// Motor command frame encoder: one 8-byte command frame per request.
// A request passes the quantiser stages, then the output register, which raises done.
// Throughput: one request per cycle while busy is low; every stage advances each cycle, nothing feeds back.
// Reset: synchronous, active high; clears all valid bits, sets motor_id to 3;
// busy is rst registered and falls in the cycle after rst. The receiver cannot stall.
// Depends on mcfe_pkg and mcfe_quant.
module mit_command_frame_encoder_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [mcfe_pkg::CMD_W-1:0]          cmd,
  input  logic signed [mcfe_pkg::IN_W-1:0]    target_position,
  input  logic signed [mcfe_pkg::IN_W-1:0]    target_velocity,
  input  logic signed [mcfe_pkg::IN_W-1:0]    stiffness_gain,
  input  logic signed [mcfe_pkg::IN_W-1:0]    damping_gain,
  input  logic signed [mcfe_pkg::IN_W-1:0]    feedforward_torque,
  input  logic                                cfg_we,
  input  logic [mcfe_pkg::ID_W-1:0]           cfg_data,
  output logic                                done,
  output logic [mcfe_pkg::ID_W-1:0]           frame_id,
  output logic [mcfe_pkg::DATA_W-1:0]         frame_data
);
  import mcfe_pkg::*;

  logic [ID_W-1:0]   motor_id;
  mcfe_tag_t         tag_in;
  mcfe_tag_t         tag_q;
  logic [DATA_W-1:0] ctrl_data;
  logic [DATA_W-1:0] frame_data_next;

  // Identifier register: written directly, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_id <= MOTOR_ID_RESET;
    end else if (cfg_we) begin
      motor_id <= cfg_data;
    end
  end

  // Hold off requests only around reset; otherwise take one every cycle
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign tag_in.valid = start & ~busy;
  assign tag_in.cmd   = cmd;

  // Quantise the set-points; the command rides alongside
  mcfe_quant u_quant (
    .clk                (clk),
    .rst                (rst),
    .tag_in             (tag_in),
    .target_position    (target_position),
    .target_velocity    (target_velocity),
    .stiffness_gain     (stiffness_gain),
    .damping_gain       (damping_gain),
    .feedforward_torque (feedforward_torque),
    .tag_out            (tag_q),
    .ctrl_data          (ctrl_data)
  );

  // Select the quantised payload or one of the fixed frames
  always_comb begin
    unique case (tag_q.cmd)
      CMD_CONTROL: frame_data_next = ctrl_data;
      CMD_ENABLE:  frame_data_next = FRAME_ENABLE;
      CMD_DISABLE: frame_data_next = FRAME_DISABLE;
      CMD_ZERO:    frame_data_next = FRAME_ZERO;
      default:     frame_data_next = ctrl_data;
    endcase
  end

  // Output register: strobe for exactly one cycle per request
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag_q.valid;
    end
    if (tag_q.valid) begin
      frame_id   <= motor_id;
      frame_data <= frame_data_next;
    end
  end

endmodule

@@ hw/rtl/mcfe_quant.sv @@
// Five-stage quantiser for the five control set-points.
// Scales, saturates and divides by each lane's span, then packs the codes.
// Depends on mcfe_pkg.
module mcfe_quant (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mcfe_pkg::mcfe_tag_t                  tag_in,
  input  logic signed [mcfe_pkg::IN_W-1:0]     target_position,
  input  logic signed [mcfe_pkg::IN_W-1:0]     target_velocity,
  input  logic signed [mcfe_pkg::IN_W-1:0]     stiffness_gain,
  input  logic signed [mcfe_pkg::IN_W-1:0]     damping_gain,
  input  logic signed [mcfe_pkg::IN_W-1:0]     feedforward_torque,
  output mcfe_pkg::mcfe_tag_t                  tag_out,
  output logic [mcfe_pkg::DATA_W-1:0]          ctrl_data
);
  import mcfe_pkg::*;

  logic signed [IN_W-1:0] x_in [NLANE];

  logic signed [XW-1:0] xs     [NLANE];
  logic [DW-1:0]        d      [NLANE];
  logic                 lo2    [NLANE];
  logic                 hi2    [NLANE];
  logic [MW-1:0]        m3     [NLANE];
  logic                 lo3    [NLANE];
  logic                 hi3    [NLANE];
  logic [MW-1:0]        m4     [NLANE];
  logic [QW-1:0]        qe     [NLANE];
  logic                 lo4    [NLANE];
  logic                 hi4    [NLANE];
  logic [QW-1:0]        code   [NLANE];

  mcfe_tag_t tag1, tag2, tag3, tag4, tag5;

  always_comb begin
    x_in[0] = target_position;
    x_in[1] = target_velocity;
    x_in[2] = stiffness_gain;
    x_in[3] = damping_gain;
    x_in[4] = feedforward_torque;
  end

  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    localparam longint ONE_S = longint'(1) << FRAC_BITS;
    localparam logic signed [XW-1:0] SC   = XW'(longint'(LANE_SCALE[g]));
    localparam logic signed [XW-1:0] LO_S = XW'(longint'(LANE_LO[g]) * ONE_S);
    localparam logic signed [XW-1:0] HI_S = XW'(longint'(LANE_HI[g]) * ONE_S);
    localparam longint SPAN = longint'(LANE_HI[g] - LANE_LO[g]);
    localparam logic [MW-1:0] SPAN_M = MW'(SPAN);
    localparam logic [MW-1:0] RECIP  = MW'((longint'(1) << RK) / SPAN);
    localparam logic [QW-1:0] MAXCODE = QW'((longint'(1) << LANE_BITS[g]) - 1);

    logic signed [XW-1:0] diff;
    logic [NW-1:0]        n;
    logic [PW-1:0]        prod;
    logic [MW-1:0]        qs;
    logic [MW-1:0]        r;
    logic [QW-1:0]        q;

    assign diff = xs[g] - LO_S;
    assign n    = (NW'(d[g]) << LANE_BITS[g]) - NW'(d[g]);
    assign prod = PW'(m3[g]) * PW'(RECIP);
    assign qs   = MW'(MW'(qe[g]) * SPAN_M);
    assign r    = m4[g] - qs;
    assign q    = (r >= SPAN_M) ? qe[g] + QW'(1) : qe[g];

    always_ff @(posedge clk) begin
      // scale
      xs[g] <= XW'(x_in[g]) * SC;
      // offset from the lower bound, flag saturation
      d[g]   <= diff[DW-1:0];
      lo2[g] <= (xs[g] <= LO_S);
      hi2[g] <= (xs[g] >= HI_S);
      // times the largest code, drop the fraction
      m3[g]  <= MW'(n >> FRAC_BITS);
      lo3[g] <= lo2[g];
      hi3[g] <= hi2[g];
      // reciprocal estimate, low by at most one
      qe[g]  <= QW'(prod >> RK);
      m4[g]  <= m3[g];
      lo4[g] <= lo3[g];
      hi4[g] <= hi3[g];
      // correct and saturate
      if (lo4[g]) begin
        code[g] <= '0;
      end else if (hi4[g]) begin
        code[g] <= MAXCODE;
      end else begin
        code[g] <= q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
      tag2.valid <= 1'b0;
      tag3.valid <= 1'b0;
      tag4.valid <= 1'b0;
      tag5.valid <= 1'b0;
    end else begin
      tag1.valid <= tag_in.valid;
      tag2.valid <= tag1.valid;
      tag3.valid <= tag2.valid;
      tag4.valid <= tag3.valid;
      tag5.valid <= tag4.valid;
    end
    tag1.cmd <= tag_in.cmd;
    tag2.cmd <= tag1.cmd;
    tag3.cmd <= tag2.cmd;
    tag4.cmd <= tag3.cmd;
    tag5.cmd <= tag4.cmd;
  end

  assign tag_out = tag5;

  always_comb begin
    ctrl_data = '0;
    for (int i = 0; i < NLANE; i++) begin
      ctrl_data = ctrl_data | (DATA_W'(code[i]) << LANE_LSB[i]);
    end
  end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the motor command frame encoder core.
// Predicts every frame with an exact integer quantiser and compares it field by field.
// Depends on mcfe_pkg and mit_command_frame_encoder_core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mcfe_pkg::*;

  typedef logic signed [IN_W-1:0] q_t;
  typedef longint unsigned u64_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
  } frame_t;

  // One unit in the Q15.16 set-point format
  localparam longint ONE = longint'(1) << FRAC_BITS;
  // Smallest raw position whose value reaches 12.57 rad: ceil(1257 * 2^16 / 100)
  localparam longint POS_EDGE = (1257 * ONE + 99) / 100;
  localparam longint VEL_EDGE = 50 * ONE;
  localparam longint KP_TOP   = 500 * ONE;
  localparam longint KD_TOP   = 5 * ONE;
  localparam longint TRQ_EDGE = 6 * ONE;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 10;   // pipeline is six deep, leave some slack
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 306;
  localparam int REPORT_CAP    = 40;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  cmd;
  q_t                target_position;
  q_t                target_velocity;
  q_t                stiffness_gain;
  q_t                damping_gain;
  q_t                feedforward_torque;
  logic              cfg_we;
  logic [ID_W-1:0]   cfg_data;
  logic              done;
  logic [ID_W-1:0]   frame_id;
  logic [DATA_W-1:0] frame_data;

  // Frames still owed by the block, oldest first
  frame_t          pending_frames[$];
  logic [ID_W-1:0] motor_id_model;
  int              n_errors;
  int              n_requests;
  int              n_frames;
  int              n_id_writes;
  int              cycle_count;
  bit              gaps_on;

  mit_command_frame_encoder_core u_dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .cmd                (cmd),
    .target_position    (target_position),
    .target_velocity    (target_velocity),
    .stiffness_gain     (stiffness_gain),
    .damping_gain       (damping_gain),
    .feedforward_torque (feedforward_torque),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .done               (done),
    .frame_id           (frame_id),
    .frame_data         (frame_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run: the slowest legal run is far below this
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Map a scaled set-point onto [0, maxcode]: clamp outside the bounds, otherwise
  // floor((x - lo) * maxcode / span) with no rounding on the way.
  function automatic u64_t quantise_code(input longint xs, input longint lo,
                                         input longint hi, input u64_t maxcode);
    if (xs <= lo) return 0;
    if (xs >= hi) return maxcode;
    return (u64_t'(xs - lo) * maxcode) / u64_t'(hi - lo);
  endfunction

  function automatic logic [DATA_W-1:0] encode_frame(input logic [CMD_W-1:0] c,
      input q_t p, input q_t v, input q_t kp, input q_t kd, input q_t t);
    logic [63:0] pos_code;
    logic [63:0] vel_code;
    logic [63:0] kp_code;
    logic [63:0] kd_code;
    logic [63:0] trq_code;
    case (c)
      CMD_ENABLE:  return FRAME_ENABLE;
      CMD_DISABLE: return FRAME_DISABLE;
      CMD_ZERO:    return FRAME_ZERO;
      default: begin
        // Position is scaled by 100 so that 12.57 rad lands on an integer bound
        pos_code = quantise_code(100 * longint'(p), -1257 * ONE, 1257 * ONE, 64'hFFFF);
        vel_code = quantise_code(longint'(v), -VEL_EDGE, VEL_EDGE, 64'hFFF);
        kp_code  = quantise_code(longint'(kp), 0, KP_TOP, 64'hFFF);
        kd_code  = quantise_code(longint'(kd), 0, KD_TOP, 64'hFFF);
        trq_code = quantise_code(longint'(t), -TRQ_EDGE, TRQ_EDGE, 64'hFFF);
        return {pos_code[15:0], vel_code[11:0], kp_code[11:0], kd_code[11:0],
                trq_code[11:0]};
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driver and checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    if (n_errors < REPORT_CAP) $display("MISMATCH @%0t: %s", $realtime, what);
    n_errors++;
  endtask

  // Hold a request on the ports until the block takes it, then log the frame it owes.
  task automatic send_request(input logic [CMD_W-1:0] c, input q_t p, input q_t v,
                              input q_t kp, input q_t kd, input q_t t, input int gap);
    frame_t owed;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start              <= 1'b1;
    cmd                <= c;
    target_position    <= p;
    target_velocity    <= v;
    stiffness_gain     <= kp;
    damping_gain       <= kd;
    feedforward_torque <= t;
    do @(posedge clk); while (busy);
    owed.id   = motor_id_model;
    owed.data = encode_frame(c, p, v, kp, kd, t);
    pending_frames.push_back(owed);
    n_requests++;
  endtask

  // Drop start and wait until every owed frame is back, then let the pipe settle.
  task automatic drain_frames();
    start <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The identifier register is only touched with the pipeline empty
  task automatic write_motor_id(input logic [ID_W-1:0] value);
    drain_frames();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we         <= 1'b0;
    motor_id_model = value;
    n_id_writes++;
  endtask

  // Each done pulse carries exactly one frame; match it against the oldest one owed
  always @(posedge clk) begin
    frame_t want;
    if (!rst && done) begin
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("frame with nothing owed: id=%0d data=%h",
                                  frame_id, frame_data));
      end else begin
        want = pending_frames.pop_front();
        n_frames++;
        if (frame_id !== want.id)
          report_mismatch($sformatf("frame_id got %0d want %0d", frame_id, want.id));
        if (frame_data !== want.data)
          report_mismatch($sformatf("frame_data got %h want %h", frame_data, want.data));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly values around the legal window, some hugging a bound, some anything at all
  function automatic q_t random_setpoint(input longint lo, input longint hi);
    longint span;
    longint pick;
    span = hi - lo;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5:
        pick = lo - span / 8 + longint'($urandom_range(0, int'(span + span / 4)));
      6, 7:
        pick = ($urandom_range(0, 1) ? hi : lo) + longint'($urandom_range(0, 8)) - 4;
      default:
        pick = longint'($signed($urandom()));
    endcase
    return q_t'(pick);
  endfunction

  function automatic int draw_gap();
    return gaps_on ? int'($urandom_range(0, 9)) : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Enable, disable and set-zero must ignore the set-points entirely
  task automatic test_fixed_frames();
    send_request(CMD_ENABLE, '1, '1, '1, '1, '1, 0);
    send_request(CMD_DISABLE, '0, '0, '0, '0, '0, 0);
    send_request(CMD_ZERO, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh5555_5555,
                 32'shAAAA_AAAA, 32'sh0000_0001, 2);
  endtask

  // Saturation on both sides, the exact bounds and one step inside them
  task automatic test_setpoint_extremes();
    send_request(CMD_CONTROL, 0, 0, 0, 0, 0, 0);
    send_request(CMD_CONTROL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_request(CMD_CONTROL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh8000_0000, 0);
    send_request(CMD_CONTROL, q_t'(POS_EDGE), q_t'(VEL_EDGE), q_t'(KP_TOP),
                 q_t'(KD_TOP), q_t'(TRQ_EDGE), 0);
    send_request(CMD_CONTROL, q_t'(POS_EDGE - 1), q_t'(VEL_EDGE - 1), q_t'(KP_TOP - 1),
                 q_t'(KD_TOP - 1), q_t'(TRQ_EDGE - 1), 1);
    send_request(CMD_CONTROL, q_t'(-POS_EDGE), q_t'(-VEL_EDGE), 0, 0,
                 q_t'(-TRQ_EDGE), 0);
    send_request(CMD_CONTROL, q_t'(-POS_EDGE + 1), q_t'(-VEL_EDGE + 1), 1, 1,
                 q_t'(-TRQ_EDGE + 1), 3);
    // negative gains clamp to code zero
    send_request(CMD_CONTROL, 0, 0, -1, -1, 0, 0);
    send_request(CMD_CONTROL, 32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
                 32'sh5555_5555, 32'sh5555_5555, 0);
    send_request(CMD_CONTROL, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                 32'shAAAA_AAAA, 32'shAAAA_AAAA, 0);
    send_request(CMD_CONTROL, 1, 1, 1, 1, 1, 0);
  endtask

  // Identifier register at both ends of its range
  task automatic test_motor_id();
    write_motor_id('0);
    send_request(CMD_CONTROL, 0, 0, 0, 0, 0, 0);
    send_request(CMD_ENABLE, 0, 0, 0, 0, 0, 0);
    write_motor_id('1);
    send_request(CMD_CONTROL, q_t'(POS_EDGE), 0, 0, 0, 0, 0);
    send_request(CMD_DISABLE, 0, 0, 0, 0, 0, 1);
  endtask

  // Long random traffic in phases, with a fresh identifier for each phase
  task automatic test_random_traffic();
    logic [CMD_W-1:0] c;
    logic [ID_W-1:0]  id_value;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        1:       id_value = '1;
        3:       id_value = '0;
        default: id_value = ID_W'($urandom_range(0, 2047));
      endcase
      write_motor_id(id_value);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // switch between gapped and back-to-back stretches
        if (k % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 9) < 7) c = CMD_CONTROL;
        else c = CMD_W'($urandom_range(1, 3));
        send_request(c,
                     random_setpoint(-POS_EDGE, POS_EDGE),
                     random_setpoint(-VEL_EDGE, VEL_EDGE),
                     random_setpoint(0, KP_TOP),
                     random_setpoint(0, KD_TOP),
                     random_setpoint(-TRQ_EDGE, TRQ_EDGE),
                     draw_gap());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    n_errors       = 0;
    n_requests     = 0;
    n_frames       = 0;
    n_id_writes    = 0;
    cycle_count    = 0;
    gaps_on        = 1'b0;
    motor_id_model = MOTOR_ID_RESET;

    rst                <= 1'b1;
    start              <= 1'b0;
    cmd                <= CMD_CONTROL;
    target_position    <= '0;
    target_velocity    <= '0;
    stiffness_gain     <= '0;
    damping_gain       <= '0;
    feedforward_torque <= '0;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // first frames run on the reset identifier
    test_fixed_frames();
    test_setpoint_extremes();
    test_motor_id();
    test_random_traffic();
    drain_frames();

    $display("Run: %0d requests, %0d frames checked, %0d identifier writes",
             n_requests, n_frames, n_id_writes);
    $display("Run: fixed frames, clamping at every bound, negative gains, random gaps");
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
